// ===== hdl/ibfc_pkg.sv =====
// shared constants and types for the ibus frame checker and compressor
package ibfc_pkg;

    // frame layout
    localparam int FRAME_BYTES = 32;
    localparam int NUM_WORDS   = 12;
    localparam int LANES       = 4;

    localparam int POS_W      = $clog2(FRAME_BYTES);
    localparam int WORD_IDX_W = $clog2(NUM_WORDS);
    localparam int SUM_W      = $clog2((FRAME_BYTES - 2) * 255 + 1);
    localparam int CHK_W      = (SUM_W > 16) ? SUM_W + 1 : 17;

    localparam logic [POS_W-1:0] LAST_POS       = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] SUM_STOP_POS   = POS_W'(FRAME_BYTES - 2);
    localparam logic [POS_W-1:0] FIRST_WORD_POS = POS_W'(3);
    localparam logic [POS_W-1:0] LAST_WORD_POS  = POS_W'(25);

    localparam logic [15:0] SUM_TARGET = 16'hffff;

    // channel groups, taken from the upper bits of the word index
    localparam logic [1:0] GROUP_FULL   = 2'd0;
    localparam logic [1:0] GROUP_MID    = 2'd1;
    localparam logic [1:0] GROUP_SWITCH = 2'd2;

    // configuration registers
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_OFFSET   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_THRESHOLD = CFG_IDX_W'(1);
    localparam logic [15:0] CHANNEL_OFFSET_RESET   = 16'd988;
    localparam logic [15:0] SWITCH_THRESHOLD_RESET = 16'd500;

    // end-of-frame queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [9:0] chan1;
        logic [9:0] chan2;
        logic [9:0] chan3;
        logic [9:0] chan4;
        logic [3:0] chan5;
        logic [3:0] chan6;
        logic [3:0] chan7;
        logic [3:0] chan8;
        logic [3:0] switch_bits;
    } result_fields_t;

    typedef struct packed {
        logic           frame_ok;
        result_fields_t fields;
    } queue_entry_t;

endpackage

// ===== hdl/ibfc_byte_if.sv =====
// byte input channel
interface ibfc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

// ===== hdl/ibfc_result_if.sv =====
// result output channel
interface ibfc_result_if;
    logic       valid;
    logic       ready;
    logic       frame_ok;
    logic [9:0] chan1;
    logic [9:0] chan2;
    logic [9:0] chan3;
    logic [9:0] chan4;
    logic [3:0] chan5;
    logic [3:0] chan6;
    logic [3:0] chan7;
    logic [3:0] chan8;
    logic [3:0] switch_bits;

    modport source (output valid, output frame_ok, output chan1, output chan2, output chan3,
                    output chan4, output chan5, output chan6, output chan7, output chan8,
                    output switch_bits, input ready);
    modport sink   (input valid, input frame_ok, input chan1, input chan2, input chan3,
                    input chan4, input chan5, input chan6, input chan7, input chan8,
                    input switch_bits, output ready);
endinterface

// ===== hdl/ibfc_cfg_if.sv =====
// configuration write channel
interface ibfc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ibfc_pkg::CFG_IDX_W-1:0]   reg_index;
    logic [15:0]                      write_data;

    modport source (output valid, output reg_index, output write_data, input ready);
    modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

// ===== hdl/ibus_frame_check_and_compress.sv =====
// top level of the ibus frame checker and channel compressor
//
//   channel      dir  transfer when         payload
//   byte_in      in   valid && ready        data_byte[7:0], frame_start
//   cfg          in   valid && ready        reg_index[3:0], write_data[15:0]
//   result_out   out  valid && ready        frame_ok, chan1..chan4[9:0],
//                                           chan5..chan8[3:0], switch_bits[3:0]
//
// one byte is taken every cycle while the end-of-frame queue is not full
// a result goes from the last byte of a frame through the queue to the output register
// byte_in.ready drops only while the two-entry end-of-frame queue is full
// reset clears position, sum, latched values and queue; no clearing pass
// cfg is always ready and takes effect for words assembled afterward
module ibus_frame_check_and_compress (
    input  logic          clk,
    input  logic          rst_n,
    ibfc_byte_if.sink     byte_in,
    ibfc_cfg_if.sink      cfg,
    ibfc_result_if.source result_out
);
    import ibfc_pkg::*;

    queue_entry_t push_entry;
    queue_entry_t head;
    logic         push, pop, queue_full, queue_empty;

    // byte classification and compression
    ibfc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // end-of-frame queue
    ibfc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (queue_full),
        .empty      (queue_empty)
    );

    // latch and result register
    ibfc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (queue_empty),
        .pop        (pop),
        .result_out (result_out)
    );

endmodule

// ===== hdl/ibfc_front.sv =====
// front end: byte position, checksum, word assembly and per-channel compression
module ibfc_front (
    input  logic                   clk,
    input  logic                   rst_n,
    ibfc_byte_if.sink              byte_in,
    ibfc_cfg_if.sink               cfg,
    input  logic                   queue_full,
    output logic                   push,
    output ibfc_pkg::queue_entry_t push_entry
);
    import ibfc_pkg::*;

    logic [15:0]           channel_offset_reg;
    logic [15:0]           switch_threshold_reg;
    logic [POS_W-1:0]      byte_count_reg, byte_count_next;
    logic [SUM_W-1:0]      running_sum_reg, running_sum_next;
    logic [7:0]            low_byte_hold_reg, low_byte_hold_next;
    logic [9:0]            chan_full_reg [LANES];
    logic [3:0]            chan_mid_reg  [LANES];
    logic [LANES-1:0]      switch_reg;

    logic                  accept;
    logic [POS_W-1:0]      pos_raw, pos, pos_off;
    logic [SUM_W-1:0]      sum_base;
    logic [15:0]           word;
    logic [CHK_W-1:0]      check_sum;
    logic                  is_last, sum_ok, is_low, is_word;
    logic [16:0]           diff;
    logic                  switch_bit;
    logic [WORD_IDX_W-1:0] word_idx;

    assign cfg.ready     = 1'b1;
    assign byte_in.ready = !queue_full;
    assign accept        = byte_in.valid && byte_in.ready;

    // classify the byte by its position in the frame
    always_comb
    begin
        pos_raw   = byte_in.frame_start ? '0 : byte_count_reg;
        pos       = (pos_raw > LAST_POS) ? '0 : pos_raw;
        pos_off   = pos - FIRST_WORD_POS;
        word_idx  = WORD_IDX_W'(pos_off >> 1);
        sum_base  = (pos == '0) ? '0 : running_sum_reg;
        word      = {byte_in.data_byte, low_byte_hold_reg};
        check_sum = CHK_W'(sum_base) + CHK_W'(word);
        is_last   = (pos == LAST_POS);
        sum_ok    = (check_sum == CHK_W'(SUM_TARGET));
        is_low    = !pos[0] || (pos == SUM_STOP_POS);
        is_word   = !is_low && (pos >= FIRST_WORD_POS) && (pos <= LAST_WORD_POS);
        // 17-bit difference of word - offset: a borrow sets diff[16] and reads as a huge unsigned value
        diff       = {1'b0, word} - {1'b0, channel_offset_reg};
        switch_bit = diff[16] || (diff[15:0] > switch_threshold_reg);
    end

    // next values of the position, sum and low byte
    always_comb
    begin
        byte_count_next    = byte_count_reg;
        running_sum_next   = running_sum_reg;
        low_byte_hold_next = low_byte_hold_reg;
        if (accept)
        begin
            if (is_last)
            begin
                byte_count_next = '0;
            end
            else
            begin
                byte_count_next  = pos + POS_W'(1);
                running_sum_next = (pos < SUM_STOP_POS) ?
                                   sum_base + SUM_W'(byte_in.data_byte) : sum_base;
                if (is_low)
                begin
                    low_byte_hold_next = byte_in.data_byte;
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg    <= '0;
            running_sum_reg   <= '0;
            low_byte_hold_reg <= '0;
        end
        else
        begin
            byte_count_reg    <= byte_count_next;
            running_sum_reg   <= running_sum_next;
            low_byte_hold_reg <= low_byte_hold_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_offset_reg   <= CHANNEL_OFFSET_RESET;
            switch_threshold_reg <= SWITCH_THRESHOLD_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            if (cfg.reg_index == REG_CHANNEL_OFFSET)
            begin
                channel_offset_reg <= cfg.write_data;
            end
            else if (cfg.reg_index == REG_SWITCH_THRESHOLD)
            begin
                switch_threshold_reg <= cfg.write_data;
            end
        end
    end

    // compressed channel capture as each word completes
    always_ff @(posedge clk)
    begin
        if (accept && !is_last && is_word)
        begin
            unique case (word_idx[WORD_IDX_W-1:2])
                GROUP_FULL:   chan_full_reg[word_idx[1:0]] <= diff[9:0];
                GROUP_MID:    chan_mid_reg[word_idx[1:0]]  <= diff[9:6];
                GROUP_SWITCH: switch_reg[word_idx[1:0]]    <= switch_bit;
                default:      ;
            endcase
        end
    end

    // end-of-frame entry into the queue
    assign push                          = accept && is_last;
    assign push_entry.frame_ok           = sum_ok;
    assign push_entry.fields.chan1       = chan_full_reg[0];
    assign push_entry.fields.chan2       = chan_full_reg[1];
    assign push_entry.fields.chan3       = chan_full_reg[2];
    assign push_entry.fields.chan4       = chan_full_reg[3];
    assign push_entry.fields.chan5       = chan_mid_reg[0];
    assign push_entry.fields.chan6       = chan_mid_reg[1];
    assign push_entry.fields.chan7       = chan_mid_reg[2];
    assign push_entry.fields.chan8       = chan_mid_reg[3];
    assign push_entry.fields.switch_bits = switch_reg;

endmodule

// ===== hdl/ibfc_queue.sv =====
// short queue of end-of-frame entries between front and back
module ibfc_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  ibfc_pkg::queue_entry_t push_entry,
    input  logic                   pop,
    output ibfc_pkg::queue_entry_t head,
    output logic                   full,
    output logic                   empty
);
    import ibfc_pkg::*;

    queue_entry_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // the front must hold off at the last byte while the queue is full
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("end-of-frame entry pushed into a full queue");

    // a lone pop takes exactly one entry
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> count_reg == $past(count_reg) - QCNT_W'(1))
        else $error("queue count did not drop on pop");

endmodule

// ===== hdl/ibfc_back.sv =====
// back end: latch on good frames and drive the registered result
module ibfc_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ibfc_pkg::queue_entry_t head,
    input  logic                   empty,
    output logic                   pop,
    ibfc_result_if.source          result_out
);
    import ibfc_pkg::*;

    result_fields_t latched_reg;
    result_fields_t out_fields_reg;
    logic           out_ok_reg;
    logic           out_valid_reg;

    assign pop = !empty && (!out_valid_reg || result_out.ready);

    // latched values and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
                if (head.frame_ok)
                begin
                    latched_reg <= head.fields;
                end
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload: new values on a good frame, previous ones otherwise
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_ok_reg     <= head.frame_ok;
            out_fields_reg <= head.frame_ok ? head.fields : latched_reg;
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.frame_ok    = out_ok_reg;
    assign result_out.chan1       = out_fields_reg.chan1;
    assign result_out.chan2       = out_fields_reg.chan2;
    assign result_out.chan3       = out_fields_reg.chan3;
    assign result_out.chan4       = out_fields_reg.chan4;
    assign result_out.chan5       = out_fields_reg.chan5;
    assign result_out.chan6       = out_fields_reg.chan6;
    assign result_out.chan7       = out_fields_reg.chan7;
    assign result_out.chan8       = out_fields_reg.chan8;
    assign result_out.switch_bits = out_fields_reg.switch_bits;

    // a good frame lands in the latch
    a_latch_on_good: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.frame_ok) |=> latched_reg == $past(head.fields))
        else $error("good frame not latched");

    // a bad frame shows the values still held in the latch
    a_bad_repeats: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ok_reg) |-> out_fields_reg == latched_reg)
        else $error("bad frame result differs from latched values");

endmodule
